### rtl/rbfs_pkg.sv
// Shared types and constants for the RBF similarity block.
// No dependencies.
package rbfs_pkg;

    localparam int DIST_W    = 38;
    localparam int DIFF_W    = 33;
    localparam int VL_W      = 7;
    localparam int BETA_W    = 24;
    localparam int WEIGHT_W  = 16;
    localparam int CFG_IDX_W = 8;
    localparam int Q_DEPTH   = 4;
    localparam int Q_PTR_W   = 2;
    localparam int Q_CNT_W   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_VECTOR_LENGTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BETA_SCALE    = 8'd1;

    localparam logic [VL_W-1:0]   VL_RESET   = 7'd40;
    localparam logic [BETA_W-1:0] BETA_RESET = 24'd83886;
    localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};
    localparam logic [31:0]       ONE_Q31    = 32'h8000_0000;

    typedef struct packed {
        logic [DIST_W-1:0] direct;
        logic [DIST_W-1:0] swapped;
    } dist_pair_t;

    typedef struct packed {
        logic              start;
        logic [DIST_W-1:0] distance;
    } ex_req_t;

    typedef struct packed {
        logic                done;
        logic [WEIGHT_W-1:0] weight;
    } ex_rsp_t;

    typedef enum logic [3:0] {
        EX_IDLE, EX_PLO, EX_PHI, EX_PSUM, EX_TMUL, EX_TDIV, EX_SMUL, EX_SRND, EX_DONE
    } ex_state_t;

    typedef enum logic [1:0] {
        BK_IDLE, BK_DIRECT, BK_SWAP, BK_LOAD
    } bk_state_t;

    function automatic logic [DIST_W-1:0] sq_sat(input logic signed [DIFF_W-1:0] d);
        logic [DIFF_W-1:0] mag;
        logic [DIST_W-1:0] m;
        mag = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        m   = {19'b0, mag[18:0]};
        if (|mag[DIFF_W-1:19]) begin
            return DIST_MAX;
        end
        return DIST_W'(m * m);
    endfunction

    function automatic logic [DIST_W-1:0] add_sat(input logic [DIST_W-1:0] a,
                                                  input logic [DIST_W-1:0] b);
        logic [DIST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[DIST_W]) begin
            return DIST_MAX;
        end
        return s[DIST_W-1:0];
    endfunction

endpackage

### rtl/rbfs_fifo.sv
// Small register queue of finished distance pairs between front and back.
// Depends on rbfs_pkg.
module rbfs_fifo (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  rbfs_pkg::dist_pair_t          push_data,
    input  logic                          pop,
    output rbfs_pkg::dist_pair_t          head,
    output logic [rbfs_pkg::Q_CNT_W-1:0]  count,
    output logic                          empty
);

    rbfs_pkg::dist_pair_t                 mem_reg [rbfs_pkg::Q_DEPTH];
    logic [rbfs_pkg::Q_PTR_W-1:0]         wr_ptr_reg, rd_ptr_reg;
    logic [rbfs_pkg::Q_CNT_W-1:0]         count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign count = count_reg;
    assign empty = (count_reg == '0);

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg != rbfs_pkg::Q_CNT_W'(rbfs_pkg::Q_DEPTH)))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (count_reg != '0))
        else $error("queue pop while empty");

endmodule

### rtl/rbfs_front.sv
// Front end: accepts element pairs, buffers first halves, squares and accumulates.
// Depends on rbfs_pkg.
module rbfs_front #(
    parameter int MAX_LENGTH   = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]    s_a_value,
    input  logic signed [SAMPLE_WIDTH-1:0]    s_b_value,
    input  logic [rbfs_pkg::VL_W-1:0]         vector_length,
    input  logic [rbfs_pkg::Q_CNT_W-1:0]      q_count,
    output logic                              push,
    output rbfs_pkg::dist_pair_t              push_data
);

    localparam int IW = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;
    localparam int HD = MAX_LENGTH / 2;
    localparam int AW = (HD > 1) ? $clog2(HD) : 1;
    localparam int CW = (IW + 1 > rbfs_pkg::VL_W) ? IW + 1 : rbfs_pkg::VL_W;
    localparam int DW = rbfs_pkg::DIST_W;

    logic [SAMPLE_WIDTH-1:0] mem_a [HD];
    logic [SAMPLE_WIDTH-1:0] mem_b [HD];

    logic [IW-1:0]  idx_reg;
    logic [CW-1:0]  vl_ext, len, half, idx_ext;
    logic           in_first, in_second, is_last, accept;
    logic [AW-1:0]  rd_addr;
    logic [rbfs_pkg::Q_CNT_W-1:0] pending;

    logic                           v1_reg, last1_reg, swap1_reg;
    logic signed [SAMPLE_WIDTH-1:0] a1_reg, b1_reg, ra1_reg, rb1_reg;
    logic                           v2_reg, last2_reg;
    logic [DW-1:0]                  sqd2_reg, sqx2_reg, sqy2_reg;
    logic [DW-1:0]                  dacc_reg, sacc_reg, dsum, ssum;
    logic signed [rbfs_pkg::DIFF_W-1:0] a1x, b1x, ra1x, rb1x;

    always_comb begin
        vl_ext  = CW'(vector_length);
        if (vl_ext < CW'(2)) begin
            len = CW'(2);
        end else if (vl_ext > CW'(MAX_LENGTH)) begin
            len = CW'(MAX_LENGTH);
        end else begin
            len = vl_ext;
        end
        half      = len >> 1;
        idx_ext   = CW'(idx_reg);
        in_first  = idx_ext < half;
        in_second = !in_first && (idx_ext < (half << 1));
        is_last   = (idx_ext + CW'(1)) >= len;
        rd_addr   = AW'(idx_ext - half);
        accept    = s_valid && s_ready;
        pending   = rbfs_pkg::Q_CNT_W'(v1_reg && last1_reg)
                  + rbfs_pkg::Q_CNT_W'(v2_reg && last2_reg);
    end

    assign s_ready = (q_count + pending) < rbfs_pkg::Q_CNT_W'(rbfs_pkg::Q_DEPTH);

    always_ff @(posedge aclk) begin
        if (accept && in_first) begin
            mem_a[AW'(idx_reg)] <= s_a_value;
            mem_b[AW'(idx_reg)] <= s_b_value;
        end
        if (accept) begin
            ra1_reg <= mem_a[rd_addr];
            rb1_reg <= mem_b[rd_addr];
            a1_reg  <= s_a_value;
            b1_reg  <= s_b_value;
        end
    end

    always_comb begin
        a1x  = rbfs_pkg::DIFF_W'(a1_reg);
        b1x  = rbfs_pkg::DIFF_W'(b1_reg);
        ra1x = rbfs_pkg::DIFF_W'(ra1_reg);
        rb1x = rbfs_pkg::DIFF_W'(rb1_reg);
    end

    always_ff @(posedge aclk) begin
        sqd2_reg <= rbfs_pkg::sq_sat(a1x - b1x);
        sqx2_reg <= swap1_reg ? rbfs_pkg::sq_sat(a1x - rb1x) : '0;
        sqy2_reg <= swap1_reg ? rbfs_pkg::sq_sat(ra1x - b1x) : '0;
    end

    always_comb begin
        dsum = rbfs_pkg::add_sat(dacc_reg, sqd2_reg);
        ssum = rbfs_pkg::add_sat(rbfs_pkg::add_sat(sacc_reg, sqx2_reg), sqy2_reg);
    end

    assign push              = v2_reg && last2_reg;
    assign push_data.direct  = dsum;
    assign push_data.swapped = ssum;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            v1_reg    <= 1'b0;
            last1_reg <= 1'b0;
            swap1_reg <= 1'b0;
            v2_reg    <= 1'b0;
            last2_reg <= 1'b0;
            dacc_reg  <= '0;
            sacc_reg  <= '0;
        end else begin
            if (accept) begin
                idx_reg <= is_last ? '0 : IW'(idx_ext + CW'(1));
            end
            v1_reg    <= accept;
            last1_reg <= accept && is_last;
            swap1_reg <= in_second;
            v2_reg    <= v1_reg;
            last2_reg <= last1_reg;
            if (v2_reg) begin
                dacc_reg <= last2_reg ? '0 : dsum;
                sacc_reg <= last2_reg ? '0 : ssum;
            end
        end
    end

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        CW'(idx_reg) < CW'(MAX_LENGTH))
        else $error("element index out of range");

    a_clear_after_push: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> (dacc_reg == '0 && sacc_reg == '0))
        else $error("accumulators not cleared after vector end");

endmodule

### rtl/rbfs_exp.sv
// Iterative exp(-beta*d) unit: shared 32x32 multiplier, radix-2 divider for the series.
// Depends on rbfs_pkg.
module rbfs_exp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [rbfs_pkg::BETA_W-1:0]   beta_scale,
    input  rbfs_pkg::ex_req_t             req,
    output rbfs_pkg::ex_rsp_t             rsp
);

    rbfs_pkg::ex_state_t state_reg, state_next;

    logic [rbfs_pkg::DIST_W-1:0] dist_reg;
    logic [63:0] prod_reg, prod_next, rnd;
    logic [42:0] plo_reg;
    logic [30:0] y_reg;
    logic        zero_reg, overflow, take, ge;
    logic [31:0] t_reg, s_reg, dvd_reg, dvd_cur, mul_a, mul_b, q;
    logic [3:0]  rem_reg;
    logic [4:0]  rem_sh, rem_new, n_reg, bit_reg;
    logic [1:0]  sq_reg;
    logic [61:0] p;
    logic [17:0] w;

    always_comb begin
        take = req.start && (state_reg == rbfs_pkg::EX_IDLE || state_reg == rbfs_pkg::EX_DONE);
        case (state_reg)
            rbfs_pkg::EX_PLO: begin
                mul_a = 32'(beta_scale);
                mul_b = 32'(dist_reg[18:0]);
            end
            rbfs_pkg::EX_PHI: begin
                mul_a = 32'(beta_scale);
                mul_b = 32'(dist_reg[37:19]);
            end
            rbfs_pkg::EX_TMUL: begin
                mul_a = t_reg;
                mul_b = {1'b0, y_reg};
            end
            rbfs_pkg::EX_SMUL: begin
                mul_a = s_reg;
                mul_b = s_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = {32'b0, mul_a} * {32'b0, mul_b};
        p         = {19'b0, plo_reg} + {prod_reg[42:0], 19'b0};
        overflow  = p[61:40] >= 22'd12;
        dvd_cur   = (bit_reg == '0) ? prod_reg[62:31] : dvd_reg;
        rem_sh    = {rem_reg, dvd_cur[31]};
        ge        = rem_sh >= n_reg;
        rem_new   = ge ? rem_sh - n_reg : rem_sh;
        q         = {dvd_cur[30:0], ge};
        rnd       = prod_reg + 64'h4000_0000;
        w         = 18'((33'(s_reg) + 33'h4000) >> 15);
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rbfs_pkg::EX_IDLE: if (take) state_next = rbfs_pkg::EX_PLO;
            rbfs_pkg::EX_PLO:  state_next = rbfs_pkg::EX_PHI;
            rbfs_pkg::EX_PHI:  state_next = rbfs_pkg::EX_PSUM;
            rbfs_pkg::EX_PSUM: state_next = overflow ? rbfs_pkg::EX_DONE : rbfs_pkg::EX_TMUL;
            rbfs_pkg::EX_TMUL: state_next = rbfs_pkg::EX_TDIV;
            rbfs_pkg::EX_TDIV: begin
                if (bit_reg == 5'd31) begin
                    state_next = (n_reg == 5'd16) ? rbfs_pkg::EX_SMUL : rbfs_pkg::EX_TMUL;
                end
            end
            rbfs_pkg::EX_SMUL: state_next = rbfs_pkg::EX_SRND;
            rbfs_pkg::EX_SRND: state_next = (sq_reg == 2'd3) ? rbfs_pkg::EX_DONE : rbfs_pkg::EX_SMUL;
            rbfs_pkg::EX_DONE: state_next = take ? rbfs_pkg::EX_PLO : rbfs_pkg::EX_IDLE;
            default:           state_next = rbfs_pkg::EX_IDLE;
        endcase
    end

    always_comb begin
        rsp.done = (state_reg == rbfs_pkg::EX_DONE);
        if (zero_reg) begin
            rsp.weight = '0;
        end else if (|w[17:16]) begin
            rsp.weight = 16'hFFFF;
        end else begin
            rsp.weight = w[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rbfs_pkg::EX_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (take) begin
            dist_reg <= req.distance;
        end
        case (state_reg)
            rbfs_pkg::EX_PHI: plo_reg <= prod_reg[42:0];
            rbfs_pkg::EX_PSUM: begin
                zero_reg <= overflow;
                y_reg    <= p[43:13];
                t_reg    <= rbfs_pkg::ONE_Q31;
                s_reg    <= rbfs_pkg::ONE_Q31;
                n_reg    <= 5'd1;
            end
            rbfs_pkg::EX_TMUL: begin
                bit_reg <= '0;
                rem_reg <= '0;
            end
            rbfs_pkg::EX_TDIV: begin
                rem_reg <= rem_new[3:0];
                dvd_reg <= q;
                bit_reg <= bit_reg + 5'd1;
                if (bit_reg == 5'd31) begin
                    t_reg  <= q;
                    s_reg  <= n_reg[0] ? s_reg - q : s_reg + q;
                    n_reg  <= n_reg + 5'd1;
                    sq_reg <= '0;
                end
            end
            rbfs_pkg::EX_SRND: begin
                s_reg  <= rnd[62:31];
                sq_reg <= sq_reg + 2'd1;
            end
            default: ;
        endcase
    end

    a_div_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rbfs_pkg::EX_TDIV) |-> (n_reg != '0 && n_reg <= 5'd16))
        else $error("series divisor out of range");

endmodule

### rtl/rbfs_back.sv
// Back end: turns each queued distance pair into two weights and holds the result.
// Depends on rbfs_pkg and rbfs_exp.
module rbfs_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [rbfs_pkg::BETA_W-1:0]      beta_scale,
    input  logic                             q_empty,
    input  rbfs_pkg::dist_pair_t             q_head,
    output logic                             q_pop,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [rbfs_pkg::WEIGHT_W-1:0]    m_weight_direct,
    output logic [rbfs_pkg::WEIGHT_W-1:0]    m_weight_swapped
);

    rbfs_pkg::bk_state_t state_reg, state_next;
    rbfs_pkg::ex_req_t   req;
    rbfs_pkg::ex_rsp_t   rsp;

    logic [rbfs_pkg::WEIGHT_W-1:0] wd_reg, ws_reg, m_wd_reg, m_ws_reg;
    logic                          m_valid_reg, load;

    rbfs_exp u_exp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .beta_scale (beta_scale),
        .req        (req),
        .rsp        (rsp)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rbfs_pkg::BK_IDLE:   if (!q_empty) state_next = rbfs_pkg::BK_DIRECT;
            rbfs_pkg::BK_DIRECT: if (rsp.done) state_next = rbfs_pkg::BK_SWAP;
            rbfs_pkg::BK_SWAP:   if (rsp.done) state_next = rbfs_pkg::BK_LOAD;
            rbfs_pkg::BK_LOAD:   if (!m_valid_reg || m_ready) state_next = rbfs_pkg::BK_IDLE;
            default:             state_next = rbfs_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        req.start    = ((state_reg == rbfs_pkg::BK_IDLE) && !q_empty)
                    || ((state_reg == rbfs_pkg::BK_DIRECT) && rsp.done);
        req.distance = (state_reg == rbfs_pkg::BK_IDLE) ? q_head.direct : q_head.swapped;
        q_pop        = (state_reg == rbfs_pkg::BK_SWAP) && rsp.done;
        load         = (state_reg == rbfs_pkg::BK_LOAD) && (!m_valid_reg || m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rbfs_pkg::BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if ((state_reg == rbfs_pkg::BK_DIRECT) && rsp.done) begin
            wd_reg <= rsp.weight;
        end
        if ((state_reg == rbfs_pkg::BK_SWAP) && rsp.done) begin
            ws_reg <= rsp.weight;
        end
        if (load) begin
            m_wd_reg <= wd_reg;
            m_ws_reg <= ws_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_weight_direct  = m_wd_reg;
    assign m_weight_swapped = m_ws_reg;

endmodule

### rtl/rbf_similarity_direct_swapped.sv
// Gaussian RBF similarity, direct and swapped halves, of two streamed Q8.8 vectors.
// Items are taken one per cycle while the four-entry distance queue has room.
// The delay from the last element of a vector to its result is set by the iterative
// exp unit (16 series terms per weight); later vectors are taken into the distance
// queue while it works, as long as the queue has room. Reset: synchronous, active-low
// aresetn; registers return to length 40 and beta 83886, no clearing pass.
module rbf_similarity_direct_swapped #(
    parameter int MAX_LENGTH   = 64,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]      s_a_value,
    input  logic signed [SAMPLE_WIDTH-1:0]      s_b_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rbfs_pkg::WEIGHT_W-1:0]       m_weight_direct,
    output logic [rbfs_pkg::WEIGHT_W-1:0]       m_weight_swapped,
    input  logic                                cfg_wr_en,
    input  logic [rbfs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rbfs_pkg::BETA_W-1:0]         cfg_wdata
);

    logic [rbfs_pkg::VL_W-1:0]    vl_reg;
    logic [rbfs_pkg::BETA_W-1:0]  beta_reg;
    logic                         push, pop, q_empty;
    rbfs_pkg::dist_pair_t         push_data, q_head;
    logic [rbfs_pkg::Q_CNT_W-1:0] q_count;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vl_reg   <= rbfs_pkg::VL_RESET;
            beta_reg <= rbfs_pkg::BETA_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rbfs_pkg::REG_VECTOR_LENGTH: vl_reg   <= cfg_wdata[rbfs_pkg::VL_W-1:0];
                rbfs_pkg::REG_BETA_SCALE:    beta_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    rbfs_front #(
        .MAX_LENGTH   (MAX_LENGTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_a_value     (s_a_value),
        .s_b_value     (s_b_value),
        .vector_length (vl_reg),
        .q_count       (q_count),
        .push          (push),
        .push_data     (push_data)
    );

    rbfs_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (q_head),
        .count     (q_count),
        .empty     (q_empty)
    );

    rbfs_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .beta_scale       (beta_reg),
        .q_empty          (q_empty),
        .q_head           (q_head),
        .q_pop            (pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_weight_direct  (m_weight_direct),
        .m_weight_swapped (m_weight_swapped)
    );

endmodule
